@@ design/lpp_pkg.sv @@
`default_nettype none

package lpp_pkg;

  // pixel coordinates carry this many fraction bits
  localparam int PIX_FRAC_BITS = 4;

  // quaternion components are Q1.14
  localparam int QSHIFT = 14;

  // quotient bits of the projection ratio: f < 2^20, |y|/x < 2^17
  localparam int FOCAL_W      = 20;
  localparam int RATIO_LIM_W  = 17;
  localparam int QUO_BITS     = FOCAL_W + RATIO_LIM_W;
  localparam int DIVD_W       = FOCAL_W + 64;
  localparam int OFF_W        = QUO_BITS + 2;

  // stage counts
  localparam int ROT_STAGES   = 8;
  localparam int RATIO_STAGES = QUO_BITS + 3;
  localparam int PIPE_DEPTH   = 1 + ROT_STAGES + 1 + ROT_STAGES + RATIO_STAGES + 1;

  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X      = 4'd0,
    CFG_FOCAL_Y      = 4'd1,
    CFG_CENTER_X     = 4'd2,
    CFG_CENTER_Y     = 4'd3,
    CFG_IMAGE_WIDTH  = 4'd4,
    CFG_IMAGE_HEIGHT = 4'd5,
    CFG_MOUNT_ROT    = 4'd6,
    CFG_MOUNT_OFF    = 4'd7
  } cfg_idx_t;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [16:0] q17_t;
  typedef logic signed [49:0] plo_t;
  typedef logic signed [48:0] phi_t;

  // operand selects of a cross product a x b, two products per component
  localparam int CA [6] = '{1, 2, 2, 0, 0, 1};
  localparam int CB [6] = '{2, 1, 0, 2, 1, 0};

  localparam s64_t RND_HALF = s64_t'(64'd1 << (QSHIFT - 1));

  // divide by 2^14, round half away from zero, 64-bit wrap
  function automatic s64_t rnd14(input s64_t x);
    s64_t a;
    a = x[63] ? -x : x;
    a = (a + RND_HALF) >>> QSHIFT;
    return x[63] ? -a : a;
  endfunction

  // a * b mod 2^64 in a 17x33 and a 17x32 partial product
  function automatic plo_t mul_lo(input q17_t a, input s64_t b);
    logic signed [32:0] bl;
    bl = {1'b0, b[31:0]};
    return plo_t'(a * bl);
  endfunction

  function automatic phi_t mul_hi(input q17_t a, input s64_t b);
    logic signed [31:0] bh;
    bh = b[63:32];
    return phi_t'(a * bh);
  endfunction

  function automatic s64_t mul_join(input plo_t lo, input phi_t hi);
    return s64_t'(lo) + s64_t'({hi[31:0], 32'd0});
  endfunction

endpackage

`default_nettype wire

@@ design/lpp_rotinv.sv @@
`default_nettype none

// inverse quaternion rotation, 8 stages, advances on adv
module lpp_rotinv (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [15:0] q_in [4],
  input  lpp_pkg::s64_t      p_in [3],
  output lpp_pkg::s64_t      p_out [3]
);
  import lpp_pkg::*;

  q17_t               nv_c [3];
  q17_t               nv1_r [3];
  q17_t               nv2_r [3];
  q17_t               nv3_r [3];
  logic signed [15:0] w1_r, w2_r, w3_r;
  s64_t               p1_r [3];
  s64_t               p2_r [3];
  s64_t               p3_r [3];
  s64_t               p4_r [3];
  s64_t               p5_r [3];
  s64_t               p6_r [3];
  s64_t               p7_r [3];
  s64_t               p8_r [3];
  plo_t               lo1_r [6];
  phi_t               hi1_r [6];
  s64_t               c2_r [3];
  s64_t               uv3_r [3];
  plo_t               lo4_r [9];
  phi_t               hi4_r [9];
  s64_t               pr5_r [9];
  s64_t               t6_r [3];
  s64_t               r7_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv_c[i] = -q17_t'(q_in[i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // c = (-v) x p, partial products
      for (int k = 0; k < 6; k++) begin
        lo1_r[k] <= mul_lo(nv_c[CA[k]], p_in[CB[k]]);
        hi1_r[k] <= mul_hi(nv_c[CA[k]], p_in[CB[k]]);
      end
      for (int i = 0; i < 3; i++) begin
        nv1_r[i] <= nv_c[i];
        p1_r[i]  <= p_in[i];
        c2_r[i]  <= mul_join(lo1_r[2*i], hi1_r[2*i]) - mul_join(lo1_r[2*i+1], hi1_r[2*i+1]);
        nv2_r[i] <= nv1_r[i];
        p2_r[i]  <= p1_r[i];
        uv3_r[i] <= rnd14({c2_r[i][62:0], 1'b0});
        nv3_r[i] <= nv2_r[i];
        p3_r[i]  <= p2_r[i];
      end
      w1_r <= q_in[0];
      w2_r <= w1_r;
      w3_r <= w2_r;
      // (-v) x uv and w*uv, partial products
      for (int k = 0; k < 6; k++) begin
        lo4_r[k] <= mul_lo(nv3_r[CA[k]], uv3_r[CB[k]]);
        hi4_r[k] <= mul_hi(nv3_r[CA[k]], uv3_r[CB[k]]);
      end
      for (int i = 0; i < 3; i++) begin
        lo4_r[6+i] <= mul_lo(q17_t'(w3_r), uv3_r[i]);
        hi4_r[6+i] <= mul_hi(q17_t'(w3_r), uv3_r[i]);
      end
      for (int k = 0; k < 9; k++) begin
        pr5_r[k] <= mul_join(lo4_r[k], hi4_r[k]);
      end
      for (int i = 0; i < 3; i++) begin
        p4_r[i] <= p3_r[i];
        p5_r[i] <= p4_r[i];
        t6_r[i] <= pr5_r[6+i] + pr5_r[2*i] - pr5_r[2*i+1];
        p6_r[i] <= p5_r[i];
        r7_r[i] <= rnd14(t6_r[i]);
        p7_r[i] <= p6_r[i];
        p8_r[i] <= p7_r[i] + r7_r[i];
      end
    end
  end

  assign p_out = p8_r;

endmodule

`default_nettype wire

@@ design/lpp_ratio.sv @@
`default_nettype none

// floor(f * num / den) by restoring division, one quotient bit per stage
module lpp_ratio (
  input  logic                             clk,
  input  logic                             adv,
  input  logic [lpp_pkg::FOCAL_W-1:0]      focal,
  input  lpp_pkg::s64_t                    num,
  input  lpp_pkg::s64_t                    den,
  output logic signed [lpp_pkg::OFF_W-1:0] off,
  output logic                             ok
);
  import lpp_pkg::*;

  logic [63:0]          a_c;
  logic                 big_c;
  logic                 den_ok_c;
  logic [FOCAL_W+31:0]  plo_r, phi_r;
  logic [62:0]          d_r   [QUO_BITS+2];
  logic                 neg_r [QUO_BITS+2];
  logic                 fz_r  [QUO_BITS+2];
  logic                 ok_r  [QUO_BITS+2];
  logic [62:0]          rem_r [QUO_BITS+1];
  logic [QUO_BITS-1:0]  low_r [QUO_BITS+1];
  logic [QUO_BITS-1:0]  quo_r [QUO_BITS+1];
  logic [DIVD_W-1:0]    divd_c;
  logic                 nz_c;
  logic signed [OFF_W-1:0] off_r;
  logic                 okf_r;

  always_comb begin
    a_c      = num[63] ? 64'(-num) : 64'(num);
    den_ok_c = (den > s64_t'(1));
    big_c    = ({16'd0, a_c} >= {den[62:0], 17'd0});
    divd_c   = DIVD_W'(plo_r) + {phi_r, 32'd0};
    nz_c     = |rem_r[QUO_BITS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // operand prep and partial products of f * |num|
      plo_r    <= focal * a_c[31:0];
      phi_r    <= focal * a_c[63:32];
      d_r[0]   <= den[62:0];
      neg_r[0] <= num[63];
      fz_r[0]  <= (focal == '0);
      ok_r[0]  <= den_ok_c && ((focal == '0) || !big_c);
      // dividend split: high part is below den when the ratio fits
      rem_r[0] <= 63'(divd_c[DIVD_W-1:QUO_BITS]);
      low_r[0] <= divd_c[QUO_BITS-1:0];
      quo_r[0] <= '0;
      d_r[1]   <= d_r[0];
      neg_r[1] <= neg_r[0];
      fz_r[1]  <= fz_r[0];
      ok_r[1]  <= ok_r[0];
      // signed result, floor toward minus infinity
      if (fz_r[QUO_BITS+1]) begin
        off_r <= '0;
      end else if (neg_r[QUO_BITS+1]) begin
        off_r <= -(OFF_W'(quo_r[QUO_BITS]) + OFF_W'(nz_c));
      end else begin
        off_r <= OFF_W'(quo_r[QUO_BITS]);
      end
      okf_r <= ok_r[QUO_BITS+1];
    end
  end

  for (genvar k = 1; k <= QUO_BITS; k++) begin : g_div
    logic [63:0] t_c;
    logic        ge_c;
    always_comb begin
      t_c  = {rem_r[k-1], low_r[k-1][QUO_BITS-1]};
      ge_c = (t_c >= {1'b0, d_r[k]});
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]   <= ge_c ? 63'(t_c - {1'b0, d_r[k]}) : t_c[62:0];
        low_r[k]   <= {low_r[k-1][QUO_BITS-2:0], 1'b0};
        quo_r[k]   <= {quo_r[k-1][QUO_BITS-2:0], ge_c};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
        fz_r[k+1]  <= fz_r[k];
        ok_r[k+1]  <= ok_r[k];
      end
    end
  end

  assign off = off_r;
  assign ok  = okf_r;

endmodule

`default_nettype wire

@@ design/landmark_pinhole_projection.sv @@
`default_nettype none

// Landmark pinhole projection.
// Input channel (in_*): one beat carries a body pose (Q1.14 quaternion, Q15.16
// position) and a world landmark. Result channel (out_*): one beat per input
// beat, in order: visible flag and Q12.4 pixel u/v (both zero when not visible).
// Config port (cfg_*): write-only, register index 0..7 in the order focal_x,
// focal_y, center_x, center_y, image_width, image_height, mount_rotation,
// mount_offset; other indexes are dropped. Write only while the block is idle.
// Throughput: one beat per cycle while the output is not stalled. A beat passes
// through the two 8-stage rotations and the 37-stage quotient divider (one bit
// per stage) that forms f*y/x and f*z/x.
// Stall: the whole pipeline freezes while out_valid is high and out_stall is
// high; in_stall follows, so nothing is lost or repeated. Empty slots move on.
// Reset (rst_n low, synchronous) clears all valid bits and loads the default
// camera: f = 500 px, center (320, 240), 640x480, identity mount, zero offset.
module landmark_pinhole_projection (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               in_pose_qw,
  input  logic signed [15:0]               in_pose_qx,
  input  logic signed [15:0]               in_pose_qy,
  input  logic signed [15:0]               in_pose_qz,
  input  logic signed [31:0]               in_pose_px,
  input  logic signed [31:0]               in_pose_py,
  input  logic signed [31:0]               in_pose_pz,
  input  logic signed [31:0]               in_mark_x,
  input  logic signed [31:0]               in_mark_y,
  input  logic signed [31:0]               in_mark_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_visible,
  output logic [15:0]                      out_pixel_u,
  output logic [15:0]                      out_pixel_v,
  input  logic                             cfg_we,
  input  logic [lpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lpp_pkg::*;

  localparam int LIM_W = 13 + PIX_FRAC_BITS;

  // camera registers
  logic [19:0] focal_x_r, focal_y_r;
  logic [15:0] center_x_r, center_y_r;
  logic [12:0] image_width_r, image_height_r;
  logic [63:0] mount_rotation_r;
  logic [62:0] mount_offset_r;

  // one valid bit per stage; the last one is out_valid
  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  adv;

  logic signed [15:0] qpose_r [4];
  logic signed [15:0] qmount_c [4];
  s64_t               rel_r [3];
  s64_t               body_c [3];
  s64_t               shift_r [3];
  s64_t               cam_c [3];

  logic signed [OFF_W-1:0] off_u, off_v;
  logic                    ok_u, ok_v;

  logic [LIM_W-1:0] wlim_c, hlim_c;
  logic [39:0]      u_c, v_c;
  logic             u_in_c, v_in_c, vis_c;

  logic        out_visible_r;
  logic [15:0] out_pixel_u_r, out_pixel_v_r;

  // whole-pipe enable: move unless a finished beat is being held
  assign adv       = !vld_r[PIPE_DEPTH-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r            <= '0;
      focal_x_r        <= 20'd8000;
      focal_y_r        <= 20'd8000;
      center_x_r       <= 16'd5120;
      center_y_r       <= 16'd3840;
      image_width_r    <= 13'd640;
      image_height_r   <= 13'd480;
      mount_rotation_r <= 64'd16384;
      mount_offset_r   <= '0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FOCAL_X:      focal_x_r        <= cfg_data[19:0];
          CFG_FOCAL_Y:      focal_y_r        <= cfg_data[19:0];
          CFG_CENTER_X:     center_x_r       <= cfg_data[15:0];
          CFG_CENTER_Y:     center_y_r       <= cfg_data[15:0];
          CFG_IMAGE_WIDTH:  image_width_r    <= cfg_data[12:0];
          CFG_IMAGE_HEIGHT: image_height_r   <= cfg_data[12:0];
          CFG_MOUNT_ROT:    mount_rotation_r <= cfg_data;
          CFG_MOUNT_OFF:    mount_offset_r   <= cfg_data[62:0];
          default: ;
        endcase
      end
    end
  end

  // stage 1: landmark relative to body, world frame
  always_ff @(posedge clk) begin
    if (adv) begin
      rel_r[0]   <= s64_t'(in_mark_x) - s64_t'(in_pose_px);
      rel_r[1]   <= s64_t'(in_mark_y) - s64_t'(in_pose_py);
      rel_r[2]   <= s64_t'(in_mark_z) - s64_t'(in_pose_pz);
      qpose_r[0] <= in_pose_qw;
      qpose_r[1] <= in_pose_qx;
      qpose_r[2] <= in_pose_qy;
      qpose_r[3] <= in_pose_qz;
    end
  end

  // world -> body
  lpp_rotinv u_rot_body (
    .clk   (clk),
    .adv   (adv),
    .q_in  (qpose_r),
    .p_in  (rel_r),
    .p_out (body_c)
  );

  // remove the mount offset (three signed 21-bit fields)
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        shift_r[i] <= body_c[i] - s64_t'($signed(mount_offset_r[21*i +: 21]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qmount_c[i] = mount_rotation_r[16*i +: 16];
    end
  end

  // body -> camera; x is depth
  lpp_rotinv u_rot_cam (
    .clk   (clk),
    .adv   (adv),
    .q_in  (qmount_c),
    .p_in  (shift_r),
    .p_out (cam_c)
  );

  lpp_ratio u_ratio_u (
    .clk   (clk),
    .adv   (adv),
    .focal (focal_x_r),
    .num   (cam_c[1]),
    .den   (cam_c[0]),
    .off   (off_u),
    .ok    (ok_u)
  );

  lpp_ratio u_ratio_v (
    .clk   (clk),
    .adv   (adv),
    .focal (focal_y_r),
    .num   (cam_c[2]),
    .den   (cam_c[0]),
    .off   (off_v),
    .ok    (ok_v)
  );

  // add principal point, bounds check against image size
  always_comb begin
    wlim_c = LIM_W'(image_width_r) << PIX_FRAC_BITS;
    hlim_c = LIM_W'(image_height_r) << PIX_FRAC_BITS;
    u_c    = {24'd0, center_x_r} + 40'(off_u);
    v_c    = {24'd0, center_y_r} + 40'(off_v);
    u_in_c = (u_c[39:16] == '0) && (u_c < 40'(wlim_c));
    v_in_c = (v_c[39:16] == '0) && (v_c < 40'(hlim_c));
    vis_c  = ok_u && ok_v && u_in_c && v_in_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_visible_r <= vis_c;
      out_pixel_u_r <= vis_c ? u_c[15:0] : 16'd0;
      out_pixel_v_r <= vis_c ? v_c[15:0] : 16'd0;
    end
  end

  assign out_visible = out_visible_r;
  assign out_pixel_u = out_pixel_u_r;
  assign out_pixel_v = out_pixel_v_r;

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_pixel_u == 16'd0 && out_pixel_v == 16'd0)
    else $error("pixel not zero for hidden landmark");

  a_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |->
      LIM_W'(out_pixel_u) < wlim_c && LIM_W'(out_pixel_v) < hlim_c)
    else $error("visible pixel outside image");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted beat lost at pipe entry");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
